// File: sv/utf8seg_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions for the utf-8 character segmenter
// no dependencies

package utf8seg_pkg;

    // default depth of the request queue between front and back (power of two, 2 and up)
    localparam int unsigned QUEUE_DEPTH = 2;

    // continuation byte pattern 10xxxxxx
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_MARK = 8'h80;

    // one input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } seg_in_t;

    // one result request
    typedef struct packed {
        logic [31:0] char_bytes;
        logic [2:0]  char_length;
        logic        end_of_string;
        logic        run_last;
    } seg_out_t;

    // classified work for one input byte: singles, optionally followed by the
    // empty end marker, or one full character
    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  single_cnt;
        logic        full;
        logic [2:0]  full_len;
        logic        marker;
        logic        eos;
    } seg_job_t;

    // sequence length announced by a lead byte
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        if (b >= 8'hC0 && b <= 8'hDF) begin
            return 3'd2;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            return 3'd3;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            return 3'd4;
        end
        return 3'd1;
    endfunction

    // number of results a job produces
    function automatic logic [2:0] job_total(input seg_job_t j);
        return j.single_cnt + {2'b00, j.full} + {2'b00, j.marker};
    endfunction

endpackage

// File: sv/utf8seg_front.sv
`timescale 1ns / 1ps
// front end: accepts bytes, tracks the held sequence and classifies each byte into a job
// depends on utf8seg_pkg

module utf8seg_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  utf8seg_pkg::seg_in_t   s_data,
    input  logic                   q_full,
    output logic                   job_push,
    output utf8seg_pkg::seg_job_t  job
);
    import utf8seg_pkg::*;

    logic [23:0] held_bytes_reg, held_bytes_next;
    logic [2:0]  expected_length_reg, expected_length_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic        terminated_reg, terminated_next;

    logic [7:0]  b;
    logic        eoi;
    logic        is_cont;
    logic        accept;
    logic [4:0]  held_shift;
    logic [31:0] with_byte;
    logic [2:0]  count_inc;
    logic [2:0]  b_len;

    assign b          = s_data.data_byte;
    assign eoi        = s_data.end_of_input;
    assign is_cont    = (b & CONT_MASK) == CONT_MARK;
    assign b_len      = lead_length(b);

    // held bytes with the new byte placed right after them
    assign held_shift = {held_count_reg, 3'b000};
    assign with_byte  = {8'h00, held_bytes_reg} | ({24'h000000, b} << held_shift);
    assign count_inc  = {1'b0, held_count_reg} + 3'd1;

    // handshake: take a byte whenever the queue has room
    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign job_push = accept && (job_total(job) != 3'd0);

    // classification and next sequence state
    always_comb begin
        job                  = '0;
        held_bytes_next      = held_bytes_reg;
        expected_length_next = expected_length_reg;
        held_count_next      = held_count_reg;
        terminated_next      = terminated_reg;

        if (terminated_reg) begin
            // skipping after nul until end of input
            if (eoi) begin
                terminated_next = 1'b0;
            end
        end else if (b == 8'h00) begin
            // nul: flush held bytes, then end marker
            job.bytes            = {8'h00, held_bytes_reg};
            job.single_cnt       = {1'b0, held_count_reg};
            job.marker           = 1'b1;
            job.eos              = 1'b1;
            held_bytes_next      = '0;
            expected_length_next = '0;
            held_count_next      = '0;
            terminated_next      = !eoi;
        end else if (expected_length_reg != 3'd0 && is_cont) begin
            // continuation of the held sequence
            if (count_inc >= expected_length_reg) begin
                job.bytes            = with_byte;
                job.full             = 1'b1;
                job.full_len         = expected_length_reg;
                held_bytes_next      = '0;
                expected_length_next = '0;
                held_count_next      = '0;
            end else if (eoi) begin
                job.bytes            = with_byte;
                job.single_cnt       = count_inc;
                held_bytes_next      = '0;
                expected_length_next = '0;
                held_count_next      = '0;
            end else begin
                held_bytes_next = with_byte[23:0];
                held_count_next = count_inc[1:0];
            end
            job.eos = eoi;
        end else begin
            // broken sequence or fresh byte: flush, then single or new lead
            job.bytes            = {8'h00, held_bytes_reg};
            job.single_cnt       = {1'b0, held_count_reg};
            held_bytes_next      = '0;
            expected_length_next = '0;
            held_count_next      = '0;
            if (b_len == 3'd1 || eoi) begin
                job.bytes      = with_byte;
                job.single_cnt = count_inc;
            end else begin
                held_bytes_next      = {16'h0000, b};
                held_count_next      = 2'd1;
                expected_length_next = b_len;
            end
            job.eos = eoi;
        end
    end

    // sequence state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_bytes_reg      <= '0;
            expected_length_reg <= '0;
            held_count_reg      <= '0;
            terminated_reg      <= 1'b0;
        end else if (accept) begin
            held_bytes_reg      <= held_bytes_next;
            expected_length_reg <= expected_length_next;
            held_count_reg      <= held_count_next;
            terminated_reg      <= terminated_next;
        end
    end

    // a sequence is held exactly when bytes are held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (expected_length_reg == 3'd0) == (held_count_reg == 2'd0))
        else $error("held count and expected length disagree");

    // never hold a complete sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        (expected_length_reg != 3'd0) |-> ({1'b0, held_count_reg} < expected_length_reg))
        else $error("held sequence already complete");

    // nul without end of input starts skipping
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !terminated_reg && b == 8'h00 && !eoi) |=> terminated_reg)
        else $error("nul did not terminate the string");

endmodule

// File: sv/utf8seg_queue.sv
`timescale 1ns / 1ps
// small register queue carrying classified jobs from front to back
// depends on utf8seg_pkg

module utf8seg_queue #(
    parameter int unsigned DEPTH = utf8seg_pkg::QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  utf8seg_pkg::seg_job_t  push_data,
    output logic                   full,
    input  logic                   pop,
    output logic                   not_empty,
    output utf8seg_pkg::seg_job_t  pop_data
);
    import utf8seg_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    seg_job_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/utf8seg_back.sv
`timescale 1ns / 1ps
// back end: walks each job one result per cycle into the output register while it is free
// depends on utf8seg_pkg

module utf8seg_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  utf8seg_pkg::seg_job_t  job,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output utf8seg_pkg::seg_out_t  m_data
);
    import utf8seg_pkg::*;

    logic [1:0]  k_reg, k_next;
    logic        m_valid_reg, m_valid_next;
    seg_out_t    m_data_reg, m_data_next;

    logic [2:0]  total;
    logic        last;
    logic        slot_free;
    logic        issue;
    logic [31:0] shifted;
    seg_out_t    res;

    assign total     = job_total(job);
    assign last      = ({1'b0, k_reg} + 3'd1) == total;
    assign slot_free = !m_valid_reg || m_ready;
    assign issue     = q_valid && slot_free;
    assign q_pop     = issue && last;
    assign shifted   = job.bytes >> {k_reg, 3'b000};

    // result for the current step of the job
    always_comb begin
        res = '0;
        if (job.full) begin
            res.char_bytes  = job.bytes;
            res.char_length = job.full_len;
        end else if ({1'b0, k_reg} < job.single_cnt) begin
            res.char_bytes  = {24'h000000, shifted[7:0]};
            res.char_length = 3'd1;
        end
        res.run_last      = last;
        res.end_of_string = last && job.eos;
    end

    // output register and step counter
    always_comb begin
        k_next       = k_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (issue) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
            k_next       = last ? 2'd0 : k_reg + 2'd1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // step counter stays inside the job at the queue head
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> ({1'b0, k_reg} < total))
        else $error("result step beyond job length");

endmodule

// File: sv/utf8_character_segmenter_core.sv
`timescale 1ns / 1ps
// top level of the utf-8 character segmenter: front, job queue and back
// depends on utf8seg_pkg, utf8seg_front, utf8seg_queue, utf8seg_back
//
// Usage:
//   s_valid/s_ready/s_data carry one string byte per request, with
//   end_of_input marking the last byte of a string. m_valid/m_ready/m_data
//   carry one character per request: its bytes (first byte lowest), its
//   length (0 for the end marker after a nul), end_of_string on the final
//   result of the string and run_last on the last result caused by a byte.
//   A byte's job is registered in the job queue, and each of its results then in the output register.
//   The front takes one byte per cycle while the job queue has room; the back
//   end issues one result per cycle while the output register is free, so a
//   byte that flushes a broken sequence yields up to four results, and while
//   they issue the job queue (QUEUE_DEPTH entries) absorbs further bytes before s_ready drops.
//   Reset (aresetn low, synchronous) empties the queue and the output
//   register and clears any held sequence and the nul skip state.
//   When the receiver stalls, the output register holds its result and the
//   front keeps taking bytes until the queue is full.

module utf8_character_segmenter_core #(
    parameter int unsigned QUEUE_DEPTH = utf8seg_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  utf8seg_pkg::seg_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output utf8seg_pkg::seg_out_t m_data
);
    import utf8seg_pkg::*;

    seg_job_t front_job;
    seg_job_t head_job;
    logic     job_push;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;

    // byte classification and sequence tracking
    utf8seg_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .job_push (job_push),
        .job      (front_job)
    );

    // decoupling queue
    utf8seg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (front_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (head_job)
    );

    // result sequencing and output register
    utf8seg_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .job     (head_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
